FILE: src/r2q_pkg.sv
// Shared widths, codes and types for the rotation matrix to quaternion core.
package r2q_pkg;

  localparam int DATA_WIDTH = 16;
  localparam int FRAC_BITS  = 12;

  localparam int SUM_W  = DATA_WIDTH + 3;
  localparam int ARG_W  = DATA_WIDTH + 1;
  localparam int V_W    = ARG_W + FRAC_BITS;
  localparam int ROOT_W = (V_W + 1) / 2;
  localparam int DEN_W  = ROOT_W + 1;
  localparam int NUM_W  = DATA_WIDTH + 1;
  localparam int DVD_W  = NUM_W + FRAC_BITS + 1;

  localparam logic signed [SUM_W-1:0] ONE = SUM_W'(1) << FRAC_BITS;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_DEGEN = 2'd1;
  localparam logic [1:0] STATUS_SAT   = 2'd2;

  localparam logic [1:0] POS_X = 2'd0;
  localparam logic [1:0] POS_Y = 2'd1;
  localparam logic [1:0] POS_Z = 2'd2;
  localparam logic [1:0] POS_W = 2'd3;

  typedef logic signed [DATA_WIDTH-1:0] data_t;
  typedef logic signed [NUM_W-1:0]      num_t;
  typedef logic signed [DVD_W:0]        quo_t;

  typedef struct packed {
    num_t       n0;
    num_t       n1;
    num_t       n2;
    logic [1:0] pos;
    logic       degen;
  } front_t;

  typedef struct packed {
    logic [ROOT_W-1:0] root;
    logic [1:0]        pos;
    logic              degen;
  } tail_t;

endpackage

FILE: src/r2q_if.sv
// Matrix and quaternion channel interfaces.
interface r2q_mat_if;
  logic          valid;
  logic          ready;
  r2q_pkg::data_t a00, a01, a02, a10, a11, a12, a20, a21, a22;
  modport source (output valid, a00, a01, a02, a10, a11, a12, a20, a21, a22, input ready);
  modport sink (input valid, a00, a01, a02, a10, a11, a12, a20, a21, a22, output ready);
endinterface

interface r2q_quat_if;
  logic           valid;
  logic           ready;
  r2q_pkg::data_t quat_x, quat_y, quat_z, quat_w;
  logic [1:0]     status;
  modport source (output valid, quat_x, quat_y, quat_z, quat_w, status, input ready);
  modport sink (input valid, quat_x, quat_y, quat_z, quat_w, status, output ready);
endinterface

FILE: src/r2q_front.sv
// Front stage: trace, branch select, root argument and numerators.
module r2q_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       vld_in,
  input  r2q_pkg::data_t             a00, a01, a02, a10, a11, a12, a20, a21, a22,
  output logic                       vld_out,
  output logic [r2q_pkg::V_W-1:0]    v_out,
  output r2q_pkg::front_t            front_out
);

  logic signed [r2q_pkg::SUM_W-1:0] e00, e11, e22, trace, arg;
  r2q_pkg::front_t                  fr;
  logic [r2q_pkg::V_W-1:0]          v;

  assign e00   = r2q_pkg::SUM_W'(a00);
  assign e11   = r2q_pkg::SUM_W'(a11);
  assign e22   = r2q_pkg::SUM_W'(a22);
  assign trace = e00 + e11 + e22;

  always_comb begin
    fr.degen = 1'b0;
    if (trace > 0) begin
      arg    = trace + r2q_pkg::ONE;
      fr.pos = r2q_pkg::POS_W;
      fr.n0  = r2q_pkg::NUM_W'(a21) - r2q_pkg::NUM_W'(a12);
      fr.n1  = r2q_pkg::NUM_W'(a02) - r2q_pkg::NUM_W'(a20);
      fr.n2  = r2q_pkg::NUM_W'(a10) - r2q_pkg::NUM_W'(a01);
    end else if ((a00 < a11) ? !(a11 < a22) : 1'b0) begin
      arg    = e11 - e22 - e00 + r2q_pkg::ONE;
      fr.pos = r2q_pkg::POS_Y;
      fr.n0  = r2q_pkg::NUM_W'(a01) + r2q_pkg::NUM_W'(a10);
      fr.n1  = r2q_pkg::NUM_W'(a12) + r2q_pkg::NUM_W'(a21);
      fr.n2  = r2q_pkg::NUM_W'(a02) - r2q_pkg::NUM_W'(a20);
    end else if ((a00 < a11) ? (a11 < a22) : (a00 < a22)) begin
      arg    = e22 - e00 - e11 + r2q_pkg::ONE;
      fr.pos = r2q_pkg::POS_Z;
      fr.n0  = r2q_pkg::NUM_W'(a20) + r2q_pkg::NUM_W'(a02);
      fr.n1  = r2q_pkg::NUM_W'(a12) + r2q_pkg::NUM_W'(a21);
      fr.n2  = r2q_pkg::NUM_W'(a10) - r2q_pkg::NUM_W'(a01);
    end else begin
      arg    = e00 - e11 - e22 + r2q_pkg::ONE;
      fr.pos = r2q_pkg::POS_X;
      fr.n0  = r2q_pkg::NUM_W'(a10) + r2q_pkg::NUM_W'(a01);
      fr.n1  = r2q_pkg::NUM_W'(a20) + r2q_pkg::NUM_W'(a02);
      fr.n2  = r2q_pkg::NUM_W'(a21) - r2q_pkg::NUM_W'(a12);
    end
    fr.degen = (arg <= 0);
    v = fr.degen ? '0 : {arg[r2q_pkg::ARG_W-1:0], {r2q_pkg::FRAC_BITS{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_out <= 1'b0;
    end else if (en) begin
      vld_out <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_out     <= v;
      front_out <= fr;
    end
  end

endmodule

FILE: src/r2q_sqrt.sv
// Pipelined integer square root, one root bit per stage.
module r2q_sqrt (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         vld_in,
  input  logic [r2q_pkg::V_W-1:0]      v_in,
  input  r2q_pkg::front_t              front_in,
  output logic                         vld_out,
  output logic [r2q_pkg::ROOT_W-1:0]   root_out,
  output r2q_pkg::front_t              front_out
);

  localparam int NS = r2q_pkg::ROOT_W;
  localparam int TW = 2 * r2q_pkg::ROOT_W + 2;

  logic                        vld  [NS+1];
  logic [r2q_pkg::V_W-1:0]     rem  [NS+1];
  logic [r2q_pkg::ROOT_W-1:0]  root [NS+1];
  r2q_pkg::front_t             fr   [NS+1];

  assign vld[0]  = vld_in;
  assign rem[0]  = v_in;
  assign root[0] = '0;
  assign fr[0]   = front_in;

  for (genvar s = 1; s <= NS; s++) begin : g_st
    localparam int B = NS - s;
    logic [TW-1:0] t;
    logic          take;
    assign t    = (TW'(root[s-1]) << (B + 1)) + (TW'(1) << (2 * B));
    assign take = TW'(rem[s-1]) >= t;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (en) begin
        vld[s] <= vld[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[s]  <= take ? rem[s-1] - t[r2q_pkg::V_W-1:0] : rem[s-1];
        root[s] <= root[s-1] | (take ? (r2q_pkg::ROOT_W'(1) << B) : '0);
        fr[s]   <= fr[s-1];
      end
    end
  end

  assign vld_out   = vld[NS];
  assign root_out  = root[NS];
  assign front_out = fr[NS];

endmodule

FILE: src/r2q_div.sv
// Three-lane pipelined restoring divider with round-half-away rounding.
module r2q_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       vld_in,
  input  r2q_pkg::num_t              num_in [3],
  input  r2q_pkg::tail_t             tail_in,
  output logic                       vld_out,
  output r2q_pkg::quo_t              quo_out [3],
  output r2q_pkg::tail_t             tail_out
);

  localparam int NS = r2q_pkg::DVD_W;
  localparam int WW = r2q_pkg::DVD_W + r2q_pkg::DEN_W;

  logic                        vld [NS+1];
  logic [r2q_pkg::DEN_W-1:0]   den [NS+1];
  r2q_pkg::tail_t              tl  [NS+1];
  logic [r2q_pkg::DVD_W-1:0]   rem [NS+1][3];
  logic [r2q_pkg::DVD_W-1:0]   quo [NS+1][3];
  logic                        neg [NS+1][3];

  logic [r2q_pkg::DEN_W-1:0]   den0;
  assign den0 = {tail_in.root, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den[0] <= den0;
      tl[0]  <= tail_in;
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_in
    logic [r2q_pkg::NUM_W-1:0] mag;
    assign mag = num_in[l][r2q_pkg::NUM_W-1] ? r2q_pkg::NUM_W'(-num_in[l])
                                             : r2q_pkg::NUM_W'(num_in[l]);
    always_ff @(posedge clk) begin
      if (en) begin
        rem[0][l] <= (r2q_pkg::DVD_W'(mag) << r2q_pkg::FRAC_BITS)
                     + r2q_pkg::DVD_W'(den0 >> 1);
        quo[0][l] <= '0;
        neg[0][l] <= num_in[l][r2q_pkg::NUM_W-1];
      end
    end
  end

  for (genvar s = 1; s <= NS; s++) begin : g_st
    localparam int B = NS - s;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (en) begin
        vld[s] <= vld[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        den[s] <= den[s-1];
        tl[s]  <= tl[s-1];
      end
    end

    for (genvar l = 0; l < 3; l++) begin : g_ln
      logic [WW-1:0] dsh;
      logic          take;
      assign dsh  = WW'(den[s-1]) << B;
      assign take = WW'(rem[s-1][l]) >= dsh;
      always_ff @(posedge clk) begin
        if (en) begin
          rem[s][l] <= take ? rem[s-1][l] - dsh[r2q_pkg::DVD_W-1:0] : rem[s-1][l];
          quo[s][l] <= quo[s-1][l] | (take ? (r2q_pkg::DVD_W'(1) << B) : '0);
          neg[s][l] <= neg[s-1][l];
        end
      end
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_out
    assign quo_out[l] = neg[NS][l] ? -r2q_pkg::quo_t'({1'b0, quo[NS][l]})
                                   : r2q_pkg::quo_t'({1'b0, quo[NS][l]});
  end

  assign vld_out  = vld[NS];
  assign tail_out = tl[NS];

endmodule

FILE: src/r2q_back.sv
// Output stage: component placement, saturation and status register.
module r2q_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              vld_in,
  input  r2q_pkg::quo_t     quo_in [3],
  input  r2q_pkg::tail_t    tail_in,
  output logic              vld_out,
  output r2q_pkg::data_t    quat_x,
  output r2q_pkg::data_t    quat_y,
  output r2q_pkg::data_t    quat_z,
  output r2q_pkg::data_t    quat_w,
  output logic [1:0]        status
);

  localparam r2q_pkg::quo_t HI = r2q_pkg::quo_t'((64'd1 << (r2q_pkg::DATA_WIDTH - 1)) - 1);
  localparam r2q_pkg::quo_t LO = -HI - 1;

  r2q_pkg::quo_t  half;
  r2q_pkg::quo_t  q   [4];
  r2q_pkg::data_t sq  [4];
  logic [3:0]     clip;

  assign half = r2q_pkg::quo_t'((r2q_pkg::DEN_W'(tail_in.root) + 1'b1) >> 1);

  always_comb begin
    case (tail_in.pos)
      r2q_pkg::POS_X: begin
        q[0] = half;      q[1] = quo_in[0]; q[2] = quo_in[1]; q[3] = quo_in[2];
      end
      r2q_pkg::POS_Y: begin
        q[0] = quo_in[0]; q[1] = half;      q[2] = quo_in[1]; q[3] = quo_in[2];
      end
      r2q_pkg::POS_Z: begin
        q[0] = quo_in[0]; q[1] = quo_in[1]; q[2] = half;      q[3] = quo_in[2];
      end
      default: begin
        q[0] = quo_in[0]; q[1] = quo_in[1]; q[2] = quo_in[2]; q[3] = half;
      end
    endcase
    for (int n = 0; n < 4; n++) begin
      clip[n] = (q[n] > HI) || (q[n] < LO);
      if (q[n] > HI) begin
        sq[n] = r2q_pkg::DATA_WIDTH'(HI);
      end else if (q[n] < LO) begin
        sq[n] = r2q_pkg::DATA_WIDTH'(LO);
      end else begin
        sq[n] = r2q_pkg::DATA_WIDTH'(q[n]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_out <= 1'b0;
    end else if (en) begin
      vld_out <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (tail_in.degen) begin
        quat_x <= '0;
        quat_y <= '0;
        quat_z <= '0;
        quat_w <= '0;
        status <= r2q_pkg::STATUS_DEGEN;
      end else begin
        quat_x <= sq[0];
        quat_y <= sq[1];
        quat_z <= sq[2];
        quat_w <= sq[3];
        status <= (|clip) ? r2q_pkg::STATUS_SAT : r2q_pkg::STATUS_OK;
      end
    end
  end

endmodule

FILE: src/rotation_matrix_to_quaternion_core.sv
// Rotation matrix to quaternion core: top level.
// Throughput: one transaction per cycle unless the output stalls; the root
// and divider pipelines, one bit per stage, set the depth.
// The whole pipeline advances when the output register is empty or taken.
// Reset (rst, synchronous) clears all valid bits; data registers are not reset.
module rotation_matrix_to_quaternion_core (
  input logic        clk,
  input logic        rst,
  r2q_mat_if.sink    mat,
  r2q_quat_if.source quat
);

  logic                        en;
  logic                        f_vld, s_vld, d_vld, b_vld;
  logic [r2q_pkg::V_W-1:0]     f_v;
  r2q_pkg::front_t             f_fr, s_fr;
  logic [r2q_pkg::ROOT_W-1:0]  s_root;
  r2q_pkg::num_t               nums [3];
  r2q_pkg::tail_t              s_tail, d_tail;
  r2q_pkg::quo_t               d_quo [3];

  assign en        = !b_vld || quat.ready;
  assign mat.ready = en;
  assign quat.valid = b_vld;

  r2q_front u_front (
    .clk, .rst, .en,
    .vld_in(mat.valid),
    .a00(mat.a00), .a01(mat.a01), .a02(mat.a02),
    .a10(mat.a10), .a11(mat.a11), .a12(mat.a12),
    .a20(mat.a20), .a21(mat.a21), .a22(mat.a22),
    .vld_out(f_vld), .v_out(f_v), .front_out(f_fr)
  );

  r2q_sqrt u_sqrt (
    .clk, .rst, .en,
    .vld_in(f_vld), .v_in(f_v), .front_in(f_fr),
    .vld_out(s_vld), .root_out(s_root), .front_out(s_fr)
  );

  assign nums[0] = s_fr.n0;
  assign nums[1] = s_fr.n1;
  assign nums[2] = s_fr.n2;
  assign s_tail  = '{root: s_root, pos: s_fr.pos, degen: s_fr.degen};

  r2q_div u_div (
    .clk, .rst, .en,
    .vld_in(s_vld), .num_in(nums), .tail_in(s_tail),
    .vld_out(d_vld), .quo_out(d_quo), .tail_out(d_tail)
  );

  r2q_back u_back (
    .clk, .rst, .en,
    .vld_in(d_vld), .quo_in(d_quo), .tail_in(d_tail),
    .vld_out(b_vld),
    .quat_x(quat.quat_x), .quat_y(quat.quat_y),
    .quat_z(quat.quat_z), .quat_w(quat.quat_w),
    .status(quat.status)
  );

endmodule

FILE: src/r2q_checker.sv
// Port-level checks for the rotation matrix to quaternion core.
module r2q_checker (
  input logic           clk,
  input logic           rst,
  input logic           mat_ready,
  input logic           quat_valid,
  input logic           quat_ready,
  input r2q_pkg::data_t quat_x,
  input r2q_pkg::data_t quat_y,
  input r2q_pkg::data_t quat_z,
  input r2q_pkg::data_t quat_w,
  input logic [1:0]     status
);

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    quat_valid |-> (status == r2q_pkg::STATUS_OK || status == r2q_pkg::STATUS_DEGEN ||
                    status == r2q_pkg::STATUS_SAT))
    else $error("status code out of range");

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    (quat_valid && status == r2q_pkg::STATUS_DEGEN) |->
      (quat_x == '0 && quat_y == '0 && quat_z == '0 && quat_w == '0))
    else $error("degenerate transaction with nonzero components");

  a_ready_flow: assert property (@(posedge clk) disable iff (rst)
    mat_ready == (!quat_valid || quat_ready))
    else $error("input ready does not follow output stall");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (quat_valid && !quat_ready) |=> (quat_valid && $stable(status) && $stable(quat_w)))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !quat_valid)
    else $error("valid result after reset");

endmodule

bind rotation_matrix_to_quaternion_core r2q_checker u_r2q_checker (
  .clk(clk), .rst(rst), .mat_ready(mat.ready),
  .quat_valid(quat.valid), .quat_ready(quat.ready),
  .quat_x(quat.quat_x), .quat_y(quat.quat_y),
  .quat_z(quat.quat_z), .quat_w(quat.quat_w),
  .status(quat.status)
);

FILE: tb/r2q_tb_pkg.sv
// Testbench-only types for the rotation matrix to quaternion regression.
`timescale 1ns / 1ps
package r2q_tb_pkg;

  typedef struct {
    r2q_pkg::data_t m [3][3];
  } matrix_t;

  typedef struct {
    r2q_pkg::data_t x, y, z, w;
    logic [1:0]     status;
  } quat_t;
endpackage

FILE: tb/rotation_matrix_to_quaternion_core_tb.sv
// Regression bench for the rotation matrix to quaternion core: table plus random stream.
`timescale 1ns / 1ps
module rotation_matrix_to_quaternion_core_tb;

  localparam int LATENCY  = r2q_pkg::ROOT_W + r2q_pkg::DVD_W + 3;
  localparam int N_RANDOM = 1800;
  localparam int N_TABLE  = 20;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #5 clk = ~clk;

  r2q_mat_if  mat ();
  r2q_quat_if quat ();

  rotation_matrix_to_quaternion_core dut (.clk(clk), .rst(rst), .mat(mat), .quat(quat));

  r2q_tb_pkg::quat_t expected_quats [$];
  int    errors = 0;
  int    n_checked = 0;
  int    n_degen = 0;
  int    n_sat = 0;
  bit    stim_done = 1'b0;
  bit    hold_off = 1'b0;

  task automatic report(input string what);
    errors++;
    $display("mismatch @%0t: %s", $realtime, what);
  endtask

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint fixed_div(input longint num, input longint unsigned den);
    longint unsigned mag, q;
    mag = (num < 0) ? longint'(-num) : num;
    q = ((mag << r2q_pkg::FRAC_BITS) + (den >> 1)) / den;
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic r2q_pkg::data_t clamp(input longint v, inout bit clipped);
    longint hi, lo;
    hi = (64'sd1 <<< (r2q_pkg::DATA_WIDTH - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      clipped = 1'b1;
      return r2q_pkg::data_t'(hi);
    end
    if (v < lo) begin
      clipped = 1'b1;
      return r2q_pkg::data_t'(lo);
    end
    return r2q_pkg::data_t'(v);
  endfunction

  function automatic r2q_tb_pkg::quat_t matrix_to_quat(input r2q_tb_pkg::matrix_t mx);
    longint a [3][3];
    longint q [4];
    longint one, trace, arg;
    longint unsigned s, den;
    int i, j, k;
    bit clipped;
    r2q_tb_pkg::quat_t r;
    one = 64'sd1 <<< r2q_pkg::FRAC_BITS;
    clipped = 1'b0;
    for (int rr = 0; rr < 3; rr++)
      for (int cc = 0; cc < 3; cc++) a[rr][cc] = mx.m[rr][cc];
    trace = a[0][0] + a[1][1] + a[2][2];
    if (trace > 0) begin
      s = int_sqrt(longint'(trace + one) << r2q_pkg::FRAC_BITS);
      den = 2 * s;
      q[3] = (s + 1) >> 1;
      q[0] = fixed_div(a[2][1] - a[1][2], den);
      q[1] = fixed_div(a[0][2] - a[2][0], den);
      q[2] = fixed_div(a[1][0] - a[0][1], den);
    end else begin
      if (a[0][0] < a[1][1]) i = (a[1][1] < a[2][2]) ? 2 : 1;
      else i = (a[0][0] < a[2][2]) ? 2 : 0;
      j = (i + 1) % 3;
      k = (i + 2) % 3;
      arg = a[i][i] - a[j][j] - a[k][k] + one;
      if (arg <= 0) begin
        r = '{x: '0, y: '0, z: '0, w: '0, status: r2q_pkg::STATUS_DEGEN};
        return r;
      end
      s = int_sqrt(longint'(arg) << r2q_pkg::FRAC_BITS);
      den = 2 * s;
      q[i] = (s + 1) >> 1;
      q[3] = fixed_div(a[k][j] - a[j][k], den);
      q[j] = fixed_div(a[j][i] + a[i][j], den);
      q[k] = fixed_div(a[k][i] + a[i][k], den);
    end
    r.x = clamp(q[0], clipped);
    r.y = clamp(q[1], clipped);
    r.z = clamp(q[2], clipped);
    r.w = clamp(q[3], clipped);
    r.status = clipped ? r2q_pkg::STATUS_SAT : r2q_pkg::STATUS_OK;
    return r;
  endfunction

  function automatic r2q_tb_pkg::matrix_t diag_matrix(input r2q_pkg::data_t d0, d1, d2,
                                                      input r2q_pkg::data_t off);
    r2q_tb_pkg::matrix_t mx;
    for (int rr = 0; rr < 3; rr++)
      for (int cc = 0; cc < 3; cc++)
        mx.m[rr][cc] = (rr == cc) ? r2q_pkg::data_t'(0) : off;
    mx.m[0][0] = d0;
    mx.m[1][1] = d1;
    mx.m[2][2] = d2;
    return mx;
  endfunction

  function automatic r2q_pkg::data_t rand_elem();
    case ($urandom_range(0, 5))
      0: return r2q_pkg::data_t'($urandom_range(0, 1) ? 16'h7fff : 16'h8000);
      1, 2: return r2q_pkg::data_t'($urandom);
      default: return r2q_pkg::data_t'(int'($urandom_range(0, 8192)) - 4096);
    endcase
  endfunction

  // Half with shaped diagonals (small, or one dominant), half left as random elements.
  function automatic r2q_tb_pkg::matrix_t rand_matrix();
    r2q_tb_pkg::matrix_t mx;
    int kind;
    kind = $urandom_range(0, 9);
    for (int rr = 0; rr < 3; rr++)
      for (int cc = 0; cc < 3; cc++) mx.m[rr][cc] = rand_elem();
    if (kind < 3) begin
      for (int rr = 0; rr < 3; rr++)
        mx.m[rr][rr] = r2q_pkg::data_t'(int'($urandom_range(0, 2000)) - 1000);
    end else if (kind < 5) begin
      int dom;
      dom = $urandom_range(0, 2);
      mx.m[dom][dom] = r2q_pkg::data_t'($urandom_range(2048, 4096));
      for (int rr = 0; rr < 3; rr++)
        if (rr != dom) mx.m[rr][rr] = r2q_pkg::data_t'(-int'($urandom_range(0, 4096)));
    end
    return mx;
  endfunction

  task automatic send(input r2q_tb_pkg::matrix_t mx);
    mat.valid <= 1'b1;
    {mat.a00, mat.a01, mat.a02} <= {mx.m[0][0], mx.m[0][1], mx.m[0][2]};
    {mat.a10, mat.a11, mat.a12} <= {mx.m[1][0], mx.m[1][1], mx.m[1][2]};
    {mat.a20, mat.a21, mat.a22} <= {mx.m[2][0], mx.m[2][1], mx.m[2][2]};
    do @(posedge clk); while (!mat.ready);
    expected_quats.push_back(matrix_to_quat(mx));
    @(negedge clk);
  endtask

  task automatic pause();
    mat.valid <= 1'b0;
    repeat ($urandom_range(1, 6)) @(negedge clk);
  endtask

  // Directed rows: matrix plus a typed-in result where known at a glance.
  r2q_tb_pkg::matrix_t tbl_m [N_TABLE];
  r2q_tb_pkg::quat_t   tbl_q [N_TABLE];
  bit                  tbl_has [N_TABLE];

  initial begin
    r2q_tb_pkg::matrix_t mx;
    r2q_pkg::data_t mx_p, mx_n;
    mx_p = 16'sh7fff;
    mx_n = 16'sh8000;
    for (int n = 0; n < N_TABLE; n++) tbl_has[n] = 1'b0;
    tbl_m[0] = diag_matrix(16'sd4096, 16'sd4096, 16'sd4096, 16'sd0);
    tbl_q[0] = '{x: 0, y: 0, z: 0, w: 16'sd4096, status: r2q_pkg::STATUS_OK};
    tbl_has[0] = 1'b1;
    tbl_m[1] = diag_matrix(16'sd0, 16'sd0, 16'sd0, 16'sd0);
    tbl_q[1] = '{x: 16'sd2048, y: 0, z: 0, w: 0, status: r2q_pkg::STATUS_OK};
    tbl_has[1] = 1'b1;
    tbl_m[2] = diag_matrix(-16'sd4096, -16'sd4096, -16'sd4096, 16'sd0);
    tbl_q[2] = '{x: 16'sd2896, y: 0, z: 0, w: 0, status: r2q_pkg::STATUS_OK};
    tbl_has[2] = 1'b1;
    tbl_m[3] = diag_matrix(-16'sd8192, 16'sd0, 16'sd0, 16'sd0);
    tbl_q[3] = '{x: 0, y: 16'sd3547, z: 0, w: 0, status: r2q_pkg::STATUS_OK};
    tbl_has[3] = 1'b1;
    tbl_m[4] = diag_matrix(mx_n, mx_p, mx_p, mx_n);
    tbl_m[5] = diag_matrix(mx_p, mx_p, mx_p, mx_n);
    tbl_m[6] = diag_matrix(mx_n, mx_n, mx_n, mx_p);
    tbl_m[7] = diag_matrix(-16'sd4096, 16'sd4096, -16'sd4096, 16'sd0);
    tbl_m[8] = diag_matrix(-16'sd4096, -16'sd4096, 16'sd4096, 16'sd0);
    tbl_m[9] = diag_matrix(-16'sd100, -16'sd100, -16'sd200, 16'sd300);
    tbl_m[10] = diag_matrix(-16'sd200, -16'sd100, -16'sd100, -16'sd300);
    tbl_m[11] = diag_matrix(-16'sd100, -16'sd100, -16'sd100, 16'sd700);
    tbl_m[12] = diag_matrix(16'sd1, 16'sd0, -16'sd1, mx_p);
    tbl_m[13] = diag_matrix(-16'sd4096, -16'sd4096, -16'sd4096, mx_n);
    tbl_m[14] = diag_matrix(-16'sd4096, -16'sd4096, -16'sd4096, mx_p);
    tbl_m[15] = diag_matrix(-16'sd4096, 16'sd0, 16'sd0, 16'sd0);
    mx = diag_matrix(16'sd0, 16'sd0, 16'sd0, 16'sd0);
    mx.m[0][1] = -16'sd4096;
    mx.m[1][0] = 16'sd4096;
    tbl_m[16] = mx;
    mx.m[2][1] = mx_p;
    mx.m[1][2] = mx_n;
    tbl_m[17] = mx;
    tbl_m[18] = diag_matrix(16'sd1, 16'sd0, 16'sd0, 16'sh5555);
    tbl_m[19] = diag_matrix(16'sh2aaa, -16'sh2aaa, 16'sd0, -16'sh5556);
  end

  initial begin
    mat.valid = 1'b0;
    {mat.a00, mat.a01, mat.a02, mat.a10, mat.a11, mat.a12, mat.a20, mat.a21, mat.a22} = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    for (int n = 0; n < N_TABLE; n++) begin
      if (tbl_has[n] && matrix_to_quat(tbl_m[n]) != tbl_q[n])
        report($sformatf("table row %0d disagrees with its typed-in result", n));
      send(tbl_m[n]);
    end
    for (int n = 0; n < N_RANDOM; ) begin
      int burst;
      burst = $urandom_range(1, 40);
      for (int b = 0; b < burst && n < N_RANDOM; b++, n++) send(rand_matrix());
      if ($urandom_range(0, 3) != 0) pause();
    end
    mat.valid <= 1'b0;
    stim_done = 1'b1;
  end

  // Receiver: own stall pattern, with one long hold-off to back up the pipe.
  initial begin
    quat.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    repeat (300) @(negedge clk);
    hold_off = 1'b1;
    quat.ready <= 1'b0;
    repeat (4 * LATENCY) @(negedge clk);
    hold_off = 1'b0;
    forever begin
      int mode;
      mode = $urandom_range(0, 7);
      repeat ($urandom_range(1, 30)) begin
        quat.ready <= (mode < 3) ? 1'b1 : ($urandom_range(0, mode) != 0);
        @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && quat.valid && quat.ready) begin
      r2q_tb_pkg::quat_t q;
      if (expected_quats.size() == 0) begin
        report("result with nothing expected");
      end else begin
        q = expected_quats.pop_front();
        n_checked++;
        if (q.status == r2q_pkg::STATUS_DEGEN) n_degen++;
        if (q.status == r2q_pkg::STATUS_SAT) n_sat++;
        if (quat.quat_x !== q.x) report($sformatf("quat_x %0d exp %0d", quat.quat_x, q.x));
        if (quat.quat_y !== q.y) report($sformatf("quat_y %0d exp %0d", quat.quat_y, q.y));
        if (quat.quat_z !== q.z) report($sformatf("quat_z %0d exp %0d", quat.quat_z, q.z));
        if (quat.quat_w !== q.w) report($sformatf("quat_w %0d exp %0d", quat.quat_w, q.w));
        if (quat.status !== q.status)
          report($sformatf("status %0d exp %0d", quat.status, q.status));
      end
    end
  end

  initial begin
    wait (stim_done);
    while (expected_quats.size() != 0) @(posedge clk);
    repeat (2 * LATENCY) @(posedge clk);
    if (expected_quats.size() != 0) report("expected results left over");
    $display("checked %0d quaternions: %0d degenerate, %0d saturated",
             n_checked, n_degen, n_sat);
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #2ms;
    $display("timeout with %0d results outstanding", expected_quats.size());
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
